// ----- rtl/siw_pkg.sv -----
`timescale 1ns / 1ps

package siw_pkg;

   // item field widths
   localparam int COV_W  = 32;
   localparam int OPA_W  = 16;
   localparam int IMP_W  = 48;

   // determinant datapath widths
   localparam int TERM_N  = 3;             // cofactor terms along the first row
   localparam int PROD_W  = 2 * COV_W;     // entry times entry
   localparam int COF_W   = PROD_W + 1;    // difference of two products
   localparam int SPLIT_W = 32;            // low slice of a cofactor
   localparam int HI_W    = COF_W - SPLIT_W;
   localparam int PART_W  = COV_W + HI_W;  // entry times one cofactor slice
   localparam int TERM_W  = PART_W + SPLIT_W;
   localparam int DET_W   = TERM_W + 1;

   // root of a value below 2^DET_W
   localparam int ROOT_W  = (DET_W + 1) / 2;
   localparam int SCALE_W = ROOT_W + OPA_W;

   // one stage of the square root chain
   typedef struct packed {
      logic              valid;
      logic [DET_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
      logic [OPA_W-1:0]  opacity;
   } sqrt_stage_type;

endpackage

// ----- rtl/siw_if.sv -----
`timescale 1ns / 1ps

interface siw_req_if import siw_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [COV_W-1:0] cov_xx;
   logic signed [COV_W-1:0] cov_xy;
   logic signed [COV_W-1:0] cov_xz;
   logic signed [COV_W-1:0] cov_yy;
   logic signed [COV_W-1:0] cov_yz;
   logic signed [COV_W-1:0] cov_zz;
   logic [OPA_W-1:0]        opacity;

   modport source (
      output valid, cov_xx, cov_xy, cov_xz, cov_yy, cov_yz, cov_zz, opacity,
      input  ready
   );

   modport sink (
      input  valid, cov_xx, cov_xy, cov_xz, cov_yy, cov_yz, cov_zz, opacity,
      output ready
   );
endinterface

interface siw_rsp_if import siw_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [IMP_W-1:0] importance;

   modport source (
      output valid, importance,
      input  ready
   );

   modport sink (
      input  valid, importance,
      output ready
   );
endinterface

// ----- rtl/siw_det.sv -----
`timescale 1ns / 1ps

module siw_det import siw_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    enable,
   input  logic                    in_valid,
   input  logic signed [COV_W-1:0] cov_xx,
   input  logic signed [COV_W-1:0] cov_xy,
   input  logic signed [COV_W-1:0] cov_xz,
   input  logic signed [COV_W-1:0] cov_yy,
   input  logic signed [COV_W-1:0] cov_yz,
   input  logic signed [COV_W-1:0] cov_zz,
   input  logic [OPA_W-1:0]        opacity,
   output sqrt_stage_type          out_stage
);

   // stage 1: entry products of the 2x2 minors
   logic signed [PROD_W-1:0] pos_in [TERM_N];
   logic signed [PROD_W-1:0] neg_in [TERM_N];
   logic signed [PROD_W-1:0] pos_ff [TERM_N];
   logic signed [PROD_W-1:0] neg_ff [TERM_N];
   logic signed [COV_W-1:0]  coef_in [TERM_N];
   logic signed [COV_W-1:0]  coef1_ff [TERM_N];
   logic [OPA_W-1:0]         op1_ff;
   logic                     valid1_ff;

   // stage 2: signed cofactors
   logic signed [COF_W-1:0]  cof_in [TERM_N];
   logic signed [COF_W-1:0]  cof_ff [TERM_N];
   logic signed [COV_W-1:0]  coef2_ff [TERM_N];
   logic [OPA_W-1:0]         op2_ff;
   logic                     valid2_ff;

   // stage 3: entry times low and high cofactor slices
   logic signed [PART_W-1:0] lo_in [TERM_N];
   logic signed [PART_W-1:0] hi_in [TERM_N];
   logic signed [PART_W-1:0] lo_ff [TERM_N];
   logic signed [PART_W-1:0] hi_ff [TERM_N];
   logic [OPA_W-1:0]         op3_ff;
   logic                     valid3_ff;

   // stage 4: recombined terms
   logic signed [TERM_W-1:0] term_in [TERM_N];
   logic signed [TERM_W-1:0] term_ff [TERM_N];
   logic [OPA_W-1:0]         op4_ff;
   logic                     valid4_ff;

   // stage 5: determinant, clamped at zero
   logic signed [DET_W-1:0]  det_in;
   sqrt_stage_type           stage_in;
   sqrt_stage_type           stage_ff;

   // det = xx*(yy*zz - yz*yz) + xy*(xz*yz - xy*zz) + xz*(xy*yz - yy*xz)
   assign pos_in[0] = PROD_W'(cov_yy) * PROD_W'(cov_zz);
   assign neg_in[0] = PROD_W'(cov_yz) * PROD_W'(cov_yz);
   assign pos_in[1] = PROD_W'(cov_xz) * PROD_W'(cov_yz);
   assign neg_in[1] = PROD_W'(cov_xy) * PROD_W'(cov_zz);
   assign pos_in[2] = PROD_W'(cov_xy) * PROD_W'(cov_yz);
   assign neg_in[2] = PROD_W'(cov_yy) * PROD_W'(cov_xz);
   assign coef_in[0] = cov_xx;
   assign coef_in[1] = cov_xy;
   assign coef_in[2] = cov_xz;

   always_comb begin
      for (int k = 0; k < TERM_N; k++) begin
         cof_in[k] = $signed({pos_ff[k][PROD_W-1], pos_ff[k]})
                   - $signed({neg_ff[k][PROD_W-1], neg_ff[k]});
         lo_in[k]  = PART_W'(coef2_ff[k])
                   * PART_W'($signed({1'b0, cof_ff[k][SPLIT_W-1:0]}));
         hi_in[k]  = PART_W'(coef2_ff[k])
                   * PART_W'($signed(cof_ff[k][COF_W-1:SPLIT_W]));
         term_in[k] = $signed({hi_ff[k], {SPLIT_W{1'b0}}})
                    + $signed({{(TERM_W-PART_W){lo_ff[k][PART_W-1]}}, lo_ff[k]});
      end
   end

   assign det_in = $signed({term_ff[0][TERM_W-1], term_ff[0]})
                 + $signed({term_ff[1][TERM_W-1], term_ff[1]})
                 + $signed({term_ff[2][TERM_W-1], term_ff[2]});

   always_comb begin
      stage_in.valid   = valid4_ff;
      stage_in.rem     = det_in[DET_W-1] ? DET_W'(0) : det_in;
      stage_in.root    = ROOT_W'(0);
      stage_in.opacity = op4_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff      <= 1'b0;
         valid2_ff      <= 1'b0;
         valid3_ff      <= 1'b0;
         valid4_ff      <= 1'b0;
         stage_ff.valid <= 1'b0;
      end else if (enable) begin
         valid1_ff <= in_valid;
         op1_ff    <= opacity;
         valid2_ff <= valid1_ff;
         op2_ff    <= op1_ff;
         valid3_ff <= valid2_ff;
         op3_ff    <= op2_ff;
         valid4_ff <= valid3_ff;
         op4_ff    <= op3_ff;
         for (int k = 0; k < TERM_N; k++) begin
            pos_ff[k]   <= pos_in[k];
            neg_ff[k]   <= neg_in[k];
            coef1_ff[k] <= coef_in[k];
            cof_ff[k]   <= cof_in[k];
            coef2_ff[k] <= coef1_ff[k];
            lo_ff[k]    <= lo_in[k];
            hi_ff[k]    <= hi_in[k];
            term_ff[k]  <= term_in[k];
         end
         stage_ff <= stage_in;
      end
   end

   assign out_stage = stage_ff;

endmodule

// ----- rtl/siw_sqrt_cell.sv -----
`timescale 1ns / 1ps

module siw_sqrt_cell import siw_pkg::*; #(
   parameter int BIT = 0
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           enable,
   input  sqrt_stage_type in_stage,
   output sqrt_stage_type out_stage
);

   logic [DET_W-1:0] trial;
   logic             fits;
   sqrt_stage_type   stage_in;
   sqrt_stage_type   stage_ff;

   // (2*root + 2^BIT) * 2^BIT, root holding only bits above BIT
   assign trial = (DET_W'(in_stage.root) << (BIT + 1)) | (DET_W'(1) << (2 * BIT));
   assign fits  = in_stage.rem >= trial;

   always_comb begin
      stage_in.valid   = in_stage.valid;
      stage_in.opacity = in_stage.opacity;
      stage_in.rem     = fits ? (in_stage.rem - trial) : in_stage.rem;
      stage_in.root    = in_stage.root | (ROOT_W'(fits) << BIT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (enable) begin
         stage_ff <= stage_in;
      end
   end

   assign out_stage = stage_ff;

endmodule

// ----- rtl/siw_rsp_skid.sv -----
`timescale 1ns / 1ps

module siw_rsp_skid import siw_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [IMP_W-1:0] in_data,
   output logic             in_ready,
   siw_rsp_if.source        rsp_chan
);

   logic             out_valid_ff, out_valid_in;
   logic [IMP_W-1:0] out_data_ff, out_data_in;
   logic             skid_valid_ff, skid_valid_in;
   logic [IMP_W-1:0] skid_data_ff, skid_data_in;
   logic             out_free;

   assign in_ready = !skid_valid_ff;
   assign out_free = !out_valid_ff || rsp_chan.ready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = in_valid;
            out_data_in  = in_data;
         end
      end else if (in_valid && !skid_valid_ff) begin
         skid_valid_in = 1'b1;
         skid_data_in  = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.importance = out_data_ff;

endmodule

// ----- rtl/splat_importance_weight.sv -----
`timescale 1ns / 1ps

// splat importance weight: opacity * sqrt(det) of a symmetric 3x3 covariance
// req_chan carries one splat per item: six covariance entries (signed fixed
// point, any fraction count) and a 0.16 opacity; rsp_chan returns one
// importance per item, floor(isqrt(max(det,0)) * opacity / 2^16), in order
// an item passes through 5 determinant stages, 49 square root cells
// (one root bit each), one opacity multiply stage and the output register
// before rsp valid rises
// throughput is one item per clock while the skid register is empty; the
// whole datapath advances together and every stage is registered
// when the receiver stalls, the output register holds its item and the next
// finished item drops into a one-entry skid register; only once the skid
// register is full does req ready fall and the pipeline freeze in place, so
// ready never depends combinationally on rsp ready
// reset (synchronous) clears all valid bits, those of both output registers
// included; there is no other state and no configuration

module splat_importance_weight import siw_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   siw_req_if.sink req_chan,
   siw_rsp_if.source rsp_chan
);

   // pipeline advance, low only while the skid register is occupied
   logic             enable;

   // square root chain, entry 0 is the clamped determinant
   sqrt_stage_type   chain [ROOT_W+1];

   // opacity scaling stage
   logic [SCALE_W-1:0] scale;
   logic [IMP_W-1:0]   imp_in, imp_ff;
   logic               imp_valid_ff;

   assign req_chan.ready = enable;

   // cofactor expansion and clamp of a negative determinant
   siw_det u_det (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (req_chan.valid),
      .cov_xx    (req_chan.cov_xx),
      .cov_xy    (req_chan.cov_xy),
      .cov_xz    (req_chan.cov_xz),
      .cov_yy    (req_chan.cov_yy),
      .cov_yz    (req_chan.cov_yz),
      .cov_zz    (req_chan.cov_zz),
      .opacity   (req_chan.opacity),
      .out_stage (chain[0])
   );

   // restoring square root, most significant root bit first
   for (genvar i = 0; i < ROOT_W; i++) begin : g_cell
      siw_sqrt_cell #(
         .BIT (ROOT_W - 1 - i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .enable    (enable),
         .in_stage  (chain[i]),
         .out_stage (chain[i+1])
      );
   end

   // root times opacity, drop the opacity fraction bits
   assign scale  = SCALE_W'(chain[ROOT_W].root) * SCALE_W'(chain[ROOT_W].opacity);
   assign imp_in = scale[OPA_W +: IMP_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         imp_valid_ff <= 1'b0;
      end else if (enable) begin
         imp_valid_ff <= chain[ROOT_W].valid;
         imp_ff       <= imp_in;
      end
   end

   // output register plus skid entry
   siw_rsp_skid u_rsp_skid (
      .clock    (clock),
      .reset    (reset),
      .in_valid (imp_valid_ff),
      .in_data  (imp_ff),
      .in_ready (enable),
      .rsp_chan (rsp_chan)
   );

endmodule
